// File: design/logistic_map_byte_generator_defines.svh
// Assertion macros shared by the logistic map byte generator checker.
`ifndef LOGISTIC_MAP_BYTE_GENERATOR_DEFINES_SVH
`define LOGISTIC_MAP_BYTE_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMBG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMBG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lmbg_pkg.sv
// Shared constants and register codes of the logistic map byte generator.
package lmbg_pkg;

  localparam int unsigned WordW         = 32;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned PrecW         = 6;
  localparam int unsigned CfgAddrW      = 4;
  localparam int unsigned IndexWidthDef = 32;
  localparam int unsigned ByteValuesDef = 256;

  localparam logic [WordW-1:0] MuReset   = 32'hc000_0000;
  localparam logic [WordW-1:0] SeedReset = 32'h8000_0000;
  localparam logic [PrecW-1:0] PrecReset = 6'd32;
  localparam logic [PrecW-1:0] PrecMax   = 6'd32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] RegMu   = 2'd0;
  localparam logic [1:0] RegSeed = 2'd1;
  localparam logic [1:0] RegPrec = 2'd2;

endpackage

// File: design/lmbg_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module lmbg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/logistic_map_byte_generator.sv
// Top level of the logistic map byte generator: datapath, table and register port.
//
// Usage: each request on the input channel (in_valid_i/in_ready_o) carries one
// noise byte and advances the 32-bit fraction x by one step of the noisy
// logistic map. Each step yields exactly one result request on the output
// channel (out_valid_o/out_ready_i): the top byte of the new x, the number of
// steps since that byte value last appeared, and the full new x.
// Only one step runs at a time: a new request is accepted only once the last
// one is back in idle, since the step is a chain of two 32-bit multiplies, a
// 62-bit add and a read-modify-write of the 256-entry table of last-seen step
// numbers, and the next step needs the x this one leaves.
// The result sits in an output register, so the next request is accepted while
// a finished result still waits. If the receiver stalls, the block runs up to
// the table write of the following step and holds there until the output
// register frees up.
// Reset loads x with the seed reset value, clears the step counter and marks
// every table entry unseen through a valid flop per entry, so no clearing pass
// is needed. The registers mu_fraction, seed_value and precision_bits sit at
// byte addresses 0, 4 and 8 of the APB-style port; writing seed_value also
// reloads x. Write registers only while the block is idle; it is not enforced.
module logistic_map_byte_generator #(
  parameter int unsigned IndexWidth = lmbg_pkg::IndexWidthDef,
  parameter int unsigned ByteValues = lmbg_pkg::ByteValuesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lmbg_pkg::CfgAddrW-1:0] paddr,
  input  logic [lmbg_pkg::WordW-1:0]    pwdata,
  output logic [lmbg_pkg::WordW-1:0]    prdata,
  output logic                          pready,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lmbg_pkg::ByteW-1:0]    noise_byte_i,
  // Output channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lmbg_pkg::ByteW-1:0]    out_byte_o,
  output logic [lmbg_pkg::WordW-1:0]    repeat_distance_o,
  output logic [lmbg_pkg::WordW-1:0]    new_value_o
);

  import lmbg_pkg::*;

  localparam int unsigned TabAddrW = $clog2(ByteValues);
  localparam int unsigned DistW    = (IndexWidth > WordW) ? IndexWidth : WordW;
  localparam int unsigned NoiseW   = ByteW + WordW - 1;  // noise shifted by up to 31
  localparam int unsigned HiW      = NoiseW - WordW;      // bits of the xor above bit 31
  localparam int unsigned KeepHiW  = 30;                  // high partial product bits kept

  // Step sequencer.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul1 = 3'd1;
  localparam logic [2:0] StMul2 = 3'd2;
  localparam logic [2:0] StSum  = 3'd3;
  localparam logic [2:0] StWb   = 3'd4;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [WordW-1:0] mu_q;
  logic [WordW-1:0] seed_q;
  logic [PrecW-1:0] prec_q;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  // Datapath state.
  logic [WordW-1:0]      x_q, x_d;
  logic [IndexWidth-1:0] step_q;
  logic [ByteW-1:0]      noise_q;
  logic [NoiseW-1:0]     mix_q;
  logic [2*WordW-1:0]    lo_q;
  logic [KeepHiW-1:0]    hi_q;
  logic [ByteValues-1:0] seen_q;

  // Output register.
  logic                  out_valid_q;
  logic [ByteW-1:0]      out_byte_q;
  logic [WordW-1:0]      dist_q;
  logic [WordW-1:0]      new_value_q;

  // Combinational datapath.
  logic [PrecW-1:0]       eff_prec;
  logic [4:0]             drop;
  logic [WordW-1:0]       keep_mask;
  logic [WordW-1:0]       x_trunc;
  logic [2*WordW-1:0]     sq_prod;
  logic [NoiseW-1:0]      noise_sh;
  logic [WordW-1:0]       factor;
  logic [2*WordW-1:0]     lo_prod;
  logic [NoiseW-1:0]      hi_prod;
  logic [2*WordW-3:0]     sum;
  logic [WordW-1:0]       x_new;
  logic [TabAddrW-1:0]    byte_idx;
  logic [TabAddrW-1:0]    tab_raddr;
  logic [IndexWidth-1:0]  tab_rdata;
  logic [IndexWidth-1:0]  last_step;
  logic [IndexWidth-1:0]  step_dist;
  logic [DistW-1:0]       dist_ext;
  logic                   in_fire;
  logic                   wb_go;

  // ------------------------------------------------------------------
  // Register port. Writes complete in the access phase; pready is tied high.
  // ------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[CfgAddrW-1:2];

  always_comb begin
    unique case (cfg_idx)
      RegMu:   prdata = mu_q;
      RegSeed: prdata = seed_q;
      RegPrec: prdata = WordW'(prec_q);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q   <= MuReset;
      seed_q <= SeedReset;
      prec_q <= PrecReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegMu:   mu_q   <= pwdata;
        RegSeed: seed_q <= pwdata;
        RegPrec: prec_q <= pwdata[PrecW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Step arithmetic.
  // ------------------------------------------------------------------
  // Precision zero behaves as one bit; anything above 32 keeps the whole word.
  always_comb begin
    priority if (prec_q == '0) begin
      eff_prec = PrecW'(1);
    end else if (prec_q > PrecMax) begin
      eff_prec = PrecMax;
    end else begin
      eff_prec = prec_q;
    end
  end

  assign drop      = 5'(PrecMax - eff_prec);
  assign keep_mask = {WordW{1'b1}} << drop;
  assign x_trunc   = x_q & keep_mask;

  // First stage: x*(1-x) as the high word of x * ~x, then the shifted noise.
  assign sq_prod  = {{WordW{1'b0}}, x_trunc} * {{WordW{1'b0}}, ~x_trunc};
  assign noise_sh = NoiseW'(noise_q) << drop;

  // Second stage: multiply by the 2.30 factor 3 + mu in two partial products.
  // Only bits 30..61 of the full product survive, so the upper partial product
  // (which lands at bit 32) needs only its low 30 bits.
  assign factor  = {2'b11, mu_q[WordW-1:2]};
  assign lo_prod = {{WordW{1'b0}}, mix_q[WordW-1:0]} * {{WordW{1'b0}}, factor};
  assign hi_prod = NoiseW'(mix_q[NoiseW-1:WordW]) * NoiseW'(factor);

  // Third stage: fold the partial products and take the new x.
  assign sum   = lo_q[2*WordW-3:0] + {hi_q, {WordW{1'b0}}};
  assign x_new = sum[2*WordW-3:KeepHiW];

  // ------------------------------------------------------------------
  // Last-seen table. The read is issued while the new x is formed, and the
  // write-back follows in StWb once the output register is free; only one step is
  // in flight, so a read never overlaps a pending write to the same entry.
  // ------------------------------------------------------------------
  assign byte_idx  = x_q[WordW-1 -: TabAddrW];
  assign tab_raddr = (state_q == StSum) ? x_new[WordW-1 -: TabAddrW] : byte_idx;
  assign wb_go     = (state_q == StWb) && (!out_valid_q || out_ready_i);

  lmbg_ram #(
    .Width (IndexWidth),
    .Depth (ByteValues)
  ) u_tab (
    .clk_i   (clk_i),
    .we_i    (wb_go),
    .waddr_i (byte_idx),
    .wdata_i (step_q),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  // An entry never written since reset counts as step zero.
  assign last_step = seen_q[byte_idx] ? tab_rdata : '0;
  assign step_dist = step_q - last_step;
  assign dist_ext  = DistW'(step_dist);

  // ------------------------------------------------------------------
  // Sequencer.
  // ------------------------------------------------------------------
  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_fire) state_d = StMul1;
      StMul1:  state_d = StMul2;
      StMul2:  state_d = StSum;
      StSum:   state_d = StWb;
      StWb:    if (wb_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    x_d = x_q;
    if (cfg_wr && (cfg_idx == RegSeed)) begin
      x_d = pwdata;
    end else if (state_q == StSum) begin
      x_d = x_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      x_q         <= SeedReset;
      step_q      <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      x_q     <= x_d;
      if (in_fire) begin
        step_q <= step_q + IndexWidth'(1);
      end
      if (wb_go) begin
        seen_q[byte_idx] <= 1'b1;
        out_valid_q      <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      noise_q <= noise_byte_i;
    end
    if (state_q == StMul1) begin
      mix_q <= {{HiW{1'b0}}, sq_prod[2*WordW-1:WordW]} ^ noise_sh;
    end
    if (state_q == StMul2) begin
      lo_q <= lo_prod;
      hi_q <= hi_prod[KeepHiW-1:0];
    end
    if (wb_go) begin
      out_byte_q  <= x_q[WordW-1 -: ByteW];
      dist_q      <= dist_ext[WordW-1:0];
      new_value_q <= x_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign repeat_distance_o = dist_q;
  assign new_value_o       = new_value_q;

endmodule

// File: design/lmbg_checker.sv
// Port-level assertions for the logistic map byte generator, bound to the top level.
`include "logistic_map_byte_generator_defines.svh"

module lmbg_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [lmbg_pkg::ByteW-1:0] out_byte_o,
  input logic [lmbg_pkg::WordW-1:0] repeat_distance_o,
  input logic [lmbg_pkg::WordW-1:0] new_value_o
);

  import lmbg_pkg::*;

  // A stalled result keeps its contents.
  `LMBG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(new_value_o) && $stable(repeat_distance_o), "stalled result changed")

  // The reported byte is always the top byte of the reported x.
  `LMBG_ASSERT_SAME(a_byte_match, out_valid_o, out_byte_o == new_value_o[WordW-1 -: ByteW], "out_byte does not match new_value")

  // Only one step is in flight: after an accept the input side closes.
  `LMBG_ASSERT_NEXT(a_one_inflight, in_valid_i && in_ready_o, !in_ready_o, "input accepted while a step was running")

  // A new result only appears at the end of a step, when the input is closed.
  `LMBG_ASSERT_SAME(a_result_from_step, $rose(out_valid_o), $past(!in_ready_o), "result appeared without a running step")

endmodule

bind logistic_map_byte_generator lmbg_checker u_lmbg_checker (.*);

// File: bench/tb_logistic_map_byte_generator.sv
// Self-checking testbench for the logistic map byte generator.
module tb_logistic_map_byte_generator;
  import lmbg_pkg::*;

  // Both sides wait up to this many cycles per request when they idle.
  localparam int unsigned MaxIdle     = 18;
  // The receiver holds off once, for a long stretch, after this many results.
  localparam int unsigned HoldAfter   = 150;
  localparam int unsigned HoldCycles  = 300;
  // Covers the block's latency with margin once both queues are empty.
  localparam int unsigned DrainCycles = 8;
  // Cycles without any request moving on either channel before giving up.
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned PhaseItems  = 80;
  localparam int unsigned PhaseCount  = 5;

  // Register index with no register behind it; writes there must be ignored.
  localparam logic [1:0]       RegUnused = 2'd3;
  localparam logic [WordW-1:0] WordMask  = '1;
  // Integer part of the 2.30 gain, which is always three.
  localparam logic [WordW-1:0] GainBase  = 32'hc000_0000;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [WordW-1:0] distance;
    logic [WordW-1:0] value;
  } step_result_t;

  // One record per offered noise byte: a typed result replaces the prediction.
  typedef struct packed {
    logic         fixed;
    step_result_t want;
  } step_plan_t;

  typedef enum logic {
    RowStep,
    RowWrite
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       reg_sel;
    logic [WordW-1:0] data;
    logic [ByteW-1:0] noise;
    logic             fixed;
    step_result_t     want;
  } row_t;

  localparam step_result_t Unset = '0;

  // Directed part. Typed results: the first step from the reset seed, x held
  // at zero by a zero noise byte, and the all-ones seed whose product vanishes.
  localparam int unsigned RowCount = 30;
  localparam row_t DirectedRows [RowCount] = '{
    '{RowStep,  RegMu,     32'h0,          8'h00, 1'b1, '{8'hef, 32'd1, 32'hefff_fffc}},
    '{RowStep,  RegMu,     32'h0,          8'hff, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'h80, 1'b0, Unset},
    // Precision zero must behave as one bit.
    '{RowWrite, RegPrec,   32'd0,          8'h00, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'hff, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'h01, 1'b0, Unset},
    '{RowWrite, RegPrec,   32'd1,          8'h00, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'h55, 1'b0, Unset},
    // Precision above 32 must behave as 32.
    '{RowWrite, RegPrec,   32'd33,         8'h00, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'haa, 1'b0, Unset},
    '{RowWrite, RegPrec,   32'd63,         8'h00, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'h7f, 1'b0, Unset},
    '{RowWrite, RegPrec,   32'd32,         8'h00, 1'b0, Unset},
    '{RowWrite, RegMu,     32'h0,          8'h00, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'h00, 1'b0, Unset},
    // Largest gain and one bit of precision: the noise lands at bit 31 and
    // the final product runs past 64 bits.
    '{RowWrite, RegMu,     32'hffff_ffff,  8'h00, 1'b0, Unset},
    '{RowWrite, RegPrec,   32'd1,          8'h00, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'hff, 1'b0, Unset},
    '{RowWrite, RegSeed,   32'h0,          8'h00, 1'b0, Unset},
    '{RowWrite, RegPrec,   32'd32,         8'h00, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'h00, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'h00, 1'b1, '{8'h00, 32'd1, 32'h0000_0000}},
    '{RowWrite, RegSeed,   32'hffff_ffff,  8'h00, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'hff, 1'b1, '{8'h00, 32'd1, 32'h0000_03fb}},
    '{RowWrite, RegUnused, 32'h1234_5678,  8'h00, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'h3c, 1'b0, Unset},
    '{RowWrite, RegSeed,   32'h8000_0000,  8'h00, 1'b0, Unset},
    '{RowWrite, RegMu,     32'hc000_0000,  8'h00, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'h00, 1'b0, Unset},
    '{RowStep,  RegMu,     32'h0,          8'h5a, 1'b0, Unset}
  };

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [CfgAddrW-1:0] paddr        = '0;
  logic [WordW-1:0]    pwdata       = '0;
  logic [WordW-1:0]    prdata;
  logic                pready;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [ByteW-1:0]    noise_byte_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [ByteW-1:0]    out_byte_o;
  logic [WordW-1:0]    repeat_distance_o;
  logic [WordW-1:0]    new_value_o;

  // Predictor copy of the registers and of the generator state.
  logic [WordW-1:0] gain_frac;
  logic [PrecW-1:0] kept_bits;
  logic [WordW-1:0] fraction;
  logic [WordW-1:0] step_count;
  logic [WordW-1:0] last_step [ByteValuesDef];

  step_plan_t   step_plans[$];
  step_result_t pending_results[$];
  int unsigned  mismatch_count = 0;

  always #5 clk_i = ~clk_i;

  logistic_map_byte_generator DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .noise_byte_i      (noise_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .repeat_distance_o (repeat_distance_o),
    .new_value_o       (new_value_o)
  );

  // One step of the noisy logistic map: truncate x, form x*(1-x), xor in the
  // noise shifted up by the dropped bits, scale by 3+mu and keep bits 30..61.
  function automatic logic [WordW-1:0] next_fraction(input logic [WordW-1:0] x,
                                                     input logic [ByteW-1:0] noise);
    int unsigned      kept;
    int unsigned      drop;
    logic [WordW-1:0] keep_mask;
    logic [WordW-1:0] trimmed;
    logic [63:0]      prod;
    logic [63:0]      gain;
    kept      = (kept_bits == 0) ? 1 : ((kept_bits > PrecMax) ? PrecMax : kept_bits);
    drop      = WordW - kept;
    keep_mask = WordMask << drop;
    trimmed   = x & keep_mask;
    prod      = ({32'd0, trimmed} * {32'd0, ~trimmed}) >> 32;
    prod      = prod ^ ({56'd0, noise} << drop);
    gain      = {32'd0, GainBase | (gain_frac >> 2)};
    prod      = prod * gain;
    return prod[61:30];
  endfunction

  // Every accepted noise byte advances the predictor and queues its result.
  always @(posedge clk_i) begin : predict_step
    step_result_t predicted;
    step_plan_t   plan;
    if (rst_ni && in_valid_i && in_ready_o) begin
      step_count = step_count + 1;
      fraction   = next_fraction(fraction, noise_byte_i);
      predicted.out_byte = fraction[31:24];
      predicted.distance = step_count - last_step[fraction[31:24]];
      predicted.value    = fraction;
      last_step[fraction[31:24]] = step_count;
      plan = step_plans.pop_front();
      pending_results.push_back(plan.fixed ? plan.want : predicted);
    end
  end

  always @(posedge clk_i) begin : compare_results
    step_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: byte %02h distance %0d value %08h",
                 $time, out_byte_o, repeat_distance_o, new_value_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $display("%0t: out_byte expected %02h, got %02h", $time, want.out_byte, out_byte_o);
          mismatch_count++;
        end
        if (repeat_distance_o !== want.distance) begin
          $display("%0t: repeat_distance expected %0d, got %0d",
                   $time, want.distance, repeat_distance_o);
          mismatch_count++;
        end
        if (new_value_o !== want.value) begin
          $display("%0t: new_value expected %08h, got %08h", $time, want.value, new_value_o);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run if neither channel moves a request for too long.
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: random stalls, stretches without stalls, and one long
  // hold-off that lets the block fill up and push back on its input.
  initial begin : result_sink
    int unsigned taken;
    int unsigned stall;
    taken = 0;
    forever begin
      if (taken == HoldAfter) begin
        stall = HoldCycles;
      end else if ((taken / 48) % 3 == 2) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MaxIdle);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
      taken++;
    end
  end

  // Offers one noise byte after an idle gap and returns at its acceptance
  // edge with valid still high, so a following byte can go out back to back.
  task automatic send_noise(input logic [ByteW-1:0] noise, input int unsigned gap,
                            input logic fixed, input step_result_t want);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    step_plans.push_back('{fixed, want});
    in_valid_i   <= 1'b1;
    noise_byte_i <= noise;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops offering and waits until the block has nothing left in flight.
  // A request still counts while its plan has not been taken by the predictor.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while ((step_plans.size() != 0) || (pending_results.size() != 0)) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] sel, input logic [WordW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      RegMu:   gain_frac = data;
      RegSeed: fraction  = data;
      RegPrec: kept_bits = data[PrecW-1:0];
      default: ;
    endcase
    // Waiting for a further clock edge keeps back-to-back writes from touching psel
    // twice in the same step.
    @(posedge clk_i);
  endtask

  initial begin : run_bench
    logic [ByteW-1:0]  noise;
    int unsigned       gap;
    gain_frac  = MuReset;
    fraction   = SeedReset;
    kept_bits  = PrecReset;
    step_count = '0;
    foreach (last_step[b]) last_step[b] = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < RowCount; r++) begin
      if (DirectedRows[r].kind == RowWrite) begin
        settle_block();
        write_register(DirectedRows[r].reg_sel, DirectedRows[r].data);
      end else begin
        send_noise(DirectedRows[r].noise, $urandom_range(0, MaxIdle),
                   DirectedRows[r].fixed, DirectedRows[r].want);
      end
    end

    // Random phases: the first two pin the gain and precision extremes, the
    // rest draw every register at random, the last with junk in the high bits
    // of the precision word.
    for (int p = 0; p < PhaseCount; p++) begin
      settle_block();
      case (p)
        0: begin
          write_register(RegMu, '0);
          write_register(RegPrec, 32'd32);
          write_register(RegSeed, $urandom());
        end
        1: begin
          write_register(RegMu, WordMask);
          write_register(RegPrec, 32'd1);
          write_register(RegSeed, WordMask);
        end
        4: begin
          write_register(RegMu, $urandom());
          write_register(RegPrec, $urandom());
          write_register(RegSeed, $urandom());
        end
        default: begin
          write_register(RegMu, $urandom());
          write_register(RegPrec, $urandom_range(0, 63));
          write_register(RegSeed, $urandom());
        end
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        case ($urandom_range(0, 7))
          0:       noise = '0;
          1:       noise = '1;
          default: noise = ByteW'($urandom_range(0, 255));
        endcase
        gap = ((i / 20) % 3 == 1) ? 0 : $urandom_range(0, MaxIdle);
        send_noise(noise, gap, 1'b0, Unset);
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/lmbg_pkg.sv
design/lmbg_ram.sv
design/logistic_map_byte_generator.sv
design/lmbg_checker.sv
bench/tb_logistic_map_byte_generator.sv
